// ----- hw/rtl/rna_pkg.sv -----
// Shared types and constants for the rational number ALU.
// No dependencies; every other file imports this package.
package rna_pkg;

   localparam int FIELD_BITS = 32;

   localparam logic [3:0] CMD_ADD = 4'd0;
   localparam logic [3:0] CMD_SUB = 4'd1;
   localparam logic [3:0] CMD_MUL = 4'd2;
   localparam logic [3:0] CMD_DIV = 4'd3;
   localparam logic [3:0] CMD_NEG = 4'd4;
   localparam logic [3:0] CMD_INV = 4'd5;
   localparam logic [3:0] CMD_EQ  = 4'd6;
   localparam logic [3:0] CMD_NE  = 4'd7;
   localparam logic [3:0] CMD_LT  = 4'd8;
   localparam logic [3:0] CMD_GT  = 4'd9;
   localparam logic [3:0] CMD_LE  = 4'd10;
   localparam logic [3:0] CMD_GE  = 4'd11;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

   typedef enum logic [1:0] {
      UOP_MUL = 2'd0,
      UOP_DIV = 2'd1,
      UOP_GCD = 2'd2
   } uop_type;

   typedef struct packed {
      logic    start;
      uop_type op;
   } unit_req_type;

endpackage

// ----- hw/rtl/rna_req_if.sv -----
// Request channel of the rational number ALU: command and two fractions.
// Depends on rna_pkg.
interface rna_req_if;
   import rna_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [3:0]                   command;
   logic signed [FIELD_BITS-1:0] a_num;
   logic signed [FIELD_BITS-1:0] a_den;
   logic signed [FIELD_BITS-1:0] b_num;
   logic signed [FIELD_BITS-1:0] b_den;

   modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

// ----- hw/rtl/rna_rsp_if.sv -----
// Response channel of the rational number ALU: result fraction and flags.
// Depends on rna_pkg.
interface rna_rsp_if;
   import rna_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] res_num;
   logic signed [FIELD_BITS-1:0] res_den;
   logic                         compare_true;
   logic [1:0]                   error_code;

   modport source (output valid, res_num, res_den, compare_true, error_code, input ready);
   modport sink   (input valid, res_num, res_den, compare_true, error_code, output ready);
endinterface

// ----- hw/rtl/rna_unit.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, binary gcd.
// One bit or one step per cycle. Depends on rna_pkg.
module rna_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rna_pkg::unit_req_type ctl,
   input  logic [WORD_BITS-1:0]  x,
   input  logic [WORD_BITS-1:0]  y,
   output logic                  done,
   output logic [WORD_BITS-1:0]  res
);
   import rna_pkg::*;

   localparam int CW = $clog2(WORD_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   uop_type              op_ff, op_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] c_ff, c_in;
   logic [WORD_BITS:0]   rem_sh;
   logic [WORD_BITS:0]   diff;
   logic                 last;

   assign rem_sh = {a_ff, c_ff[WORD_BITS-1]};
   assign diff   = rem_sh - {1'b0, b_ff};
   assign last   = (cnt_ff == CW'(WORD_BITS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '0;
         case (ctl.op)
            UOP_MUL: begin
               a_in = '0;
               b_in = x;
               c_in = y;
            end
            UOP_DIV: begin
               a_in = '0;
               b_in = y;
               c_in = x;
            end
            default: begin
               a_in = x;
               b_in = y;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            UOP_MUL: begin
               if (c_ff[0]) a_in = a_ff + b_ff;
               b_in   = b_ff << 1;
               c_in   = c_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
               if (last) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            UOP_DIV: begin
               if (!diff[WORD_BITS]) begin
                  a_in = diff[WORD_BITS-1:0];
                  c_in = {c_ff[WORD_BITS-2:0], 1'b1};
               end else begin
                  a_in = rem_sh[WORD_BITS-1:0];
                  c_in = {c_ff[WORD_BITS-2:0], 1'b0};
               end
               cnt_in = cnt_ff + 1'b1;
               if (last) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               // binary gcd: strip common twos into cnt, then subtract
               if (a_ff == '0 || b_ff == '0) begin
                  a_in    = (a_ff == '0 ? b_ff : a_ff) << cnt_ff;
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else if (!a_ff[0] && !b_ff[0]) begin
                  a_in   = a_ff >> 1;
                  b_in   = b_ff >> 1;
                  cnt_in = cnt_ff + 1'b1;
               end else if (!a_ff[0]) begin
                  a_in = a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_in = b_ff >> 1;
               end else if (a_ff >= b_ff) begin
                  a_in = a_ff - b_ff;
               end else begin
                  b_in = b_ff - a_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
   end

   assign done = done_ff;
   assign res  = (op_ff == UOP_DIV) ? c_ff : a_ff;

endmodule

// ----- hw/rtl/rational_number_alu_unit.sv -----
// Rational number ALU: add, sub, mul, div, neg, inv and six compares on
// two signed fractions. Depends on rna_pkg, rna_req_if, rna_rsp_if, rna_unit.
//
// Usage: present a command and the fractions a and b on req_ch; a transfer
// happens when valid and ready are both high. Exactly one result follows on
// rsp_ch and is held until the receiver takes it; a stalled receiver simply
// holds the block in its result state. req_ch.ready is high only while the
// block is idle, so one item is in flight at a time.
// All multiplies, divides and gcds run through one iterative unit at one
// bit or one step per cycle. Errors, unused commands, neg and inv answer in
// the cycle after the transfer. mul and div reduce their product with a gcd;
// add and sub scale both fractions to the lcm of the denominators, compares
// take one more multiply; eq/ne run two gcd and four divides. Reset returns
// the sequencer to idle with no result pending.
module rational_number_alu_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   rna_req_if.sink   req_ch,
   rna_rsp_if.source rsp_ch
);
   import rna_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_LCM_GCD  = 16'h0002,
      ST_LCM_DIV  = 16'h0004,
      ST_LCM_MUL  = 16'h0008,
      ST_SCL_DIVA = 16'h0010,
      ST_SCL_MULA = 16'h0020,
      ST_SCL_DIVB = 16'h0040,
      ST_SCL_MULB = 16'h0080,
      ST_SIGN_MUL = 16'h0100,
      ST_PRD_NUM  = 16'h0200,
      ST_PRD_DEN  = 16'h0400,
      ST_RED_GCD  = 16'h0800,
      ST_RED_NUM  = 16'h1000,
      ST_RED_DEN  = 16'h2000,
      ST_EQ_SWAP  = 16'h4000,
      ST_DONE     = 16'h8000
   } state_type;

   typedef logic [WORD_BITS-1:0] word_type;

   function automatic word_type mag(input word_type v);
      return v[WORD_BITS-1] ? word_type'(-v) : v;
   endfunction

   function automatic word_type sgn(input word_type q, input logic neg);
      return neg ? word_type'(-q) : q;
   endfunction

   state_type    state_ff, state_in;
   logic         issued_ff, issued_in;
   logic         second_ff, second_in;
   logic [3:0]   cmd_ff, cmd_in;
   word_type     an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   word_type     rn_ff, rn_in, rd_ff, rd_in, pn_ff, pn_in, pd_ff, pd_in;
   word_type     g_ff, g_in, t_ff, t_in, l_ff, l_in;
   logic         cmp_ff, cmp_in;
   logic [1:0]   err_ff, err_in;

   word_type     an_w, ad_w, bn_w, bd_w;
   word_type     u_x, u_y, u_res, p;
   logic         u_done, op_state;
   unit_req_type u_ctl;

   assign an_w = WORD_BITS'($signed(req_ch.a_num));
   assign ad_w = WORD_BITS'($signed(req_ch.a_den));
   assign bn_w = WORD_BITS'($signed(req_ch.b_num));
   assign bd_w = WORD_BITS'($signed(req_ch.b_den));

   assign op_state = !(state_ff == ST_IDLE || state_ff == ST_DONE ||
                       state_ff == ST_EQ_SWAP);

   // operand selection for the shared unit
   always_comb begin
      u_ctl.start = op_state && !issued_ff;
      u_ctl.op    = UOP_MUL;
      u_x         = '0;
      u_y         = '0;
      case (state_ff)
         ST_LCM_GCD: begin
            u_ctl.op = UOP_GCD; u_x = mag(ad_ff); u_y = mag(bd_ff);
         end
         ST_LCM_DIV: begin
            u_ctl.op = UOP_DIV; u_x = mag(ad_ff); u_y = g_ff;
         end
         ST_LCM_MUL:  begin u_x = t_ff;  u_y = mag(bd_ff); end
         ST_SCL_DIVA: begin
            u_ctl.op = UOP_DIV; u_x = mag(l_ff); u_y = mag(ad_ff);
         end
         ST_SCL_MULA: begin u_x = an_ff; u_y = t_ff; end
         ST_SCL_DIVB: begin
            u_ctl.op = UOP_DIV; u_x = mag(l_ff); u_y = mag(bd_ff);
         end
         ST_SCL_MULB: begin u_x = bn_ff; u_y = t_ff; end
         ST_SIGN_MUL: begin u_x = rn_ff; u_y = rd_ff; end
         ST_PRD_NUM:  begin u_x = an_ff; u_y = bn_ff; end
         ST_PRD_DEN:  begin u_x = ad_ff; u_y = bd_ff; end
         ST_RED_GCD: begin
            u_ctl.op = UOP_GCD; u_x = mag(rn_ff); u_y = mag(rd_ff);
         end
         ST_RED_NUM: begin
            u_ctl.op = UOP_DIV; u_x = mag(rn_ff); u_y = g_ff;
         end
         ST_RED_DEN: begin
            u_ctl.op = UOP_DIV; u_x = mag(rd_ff); u_y = g_ff;
         end
         default: ;
      endcase
   end

   rna_unit #(.WORD_BITS(WORD_BITS)) u_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (u_ctl),
      .x     (u_x),
      .y     (u_y),
      .done  (u_done),
      .res   (u_res)
   );

   assign p  = u_res;

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      second_in = second_ff;
      cmd_in    = cmd_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      rn_in = rn_ff; rd_in = rd_ff; pn_in = pn_ff; pd_in = pd_ff;
      g_in  = g_ff;  t_in  = t_ff;  l_in  = l_ff;
      cmp_in = cmp_ff;
      err_in = err_ff;

      if (u_ctl.start) issued_in = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in    = req_ch.command;
               an_in     = an_w;
               ad_in     = ad_w;
               bn_in     = bn_w;
               bd_in     = bd_w;
               second_in = 1'b0;
               issued_in = 1'b0;
               rn_in     = '0;
               rd_in     = '0;
               cmp_in    = 1'b0;
               err_in    = ERR_OK;
               state_in  = ST_DONE;
               if (req_ch.command > CMD_GE) begin
                  // unused command: all fields zero
               end else if (ad_w == '0 || (!(req_ch.command inside {CMD_NEG, CMD_INV})
                                           && bd_w == '0)) begin
                  err_in = ERR_ZERO_DEN;
               end else if ((req_ch.command == CMD_DIV && bn_w == '0) ||
                            (req_ch.command == CMD_INV && an_w == '0)) begin
                  err_in = ERR_DIV_ZERO;
               end else begin
                  case (req_ch.command)
                     CMD_NEG: begin
                        rn_in = word_type'(-an_w); rd_in = ad_w;
                     end
                     CMD_INV: begin
                        rn_in = ad_w; rd_in = an_w;
                     end
                     CMD_MUL: state_in = ST_PRD_NUM;
                     CMD_DIV: begin
                        bn_in = bd_w; bd_in = bn_w;
                        state_in = ST_PRD_NUM;
                     end
                     CMD_EQ, CMD_NE: begin
                        // bring a to a positive denominator, then reduce
                        rn_in = sgn(an_w, ad_w[WORD_BITS-1]);
                        rd_in = sgn(ad_w, ad_w[WORD_BITS-1]);
                        state_in = ST_RED_GCD;
                     end
                     CMD_ADD: state_in = ST_LCM_GCD;
                     default: begin
                        bn_in = word_type'(-bn_w);
                        state_in = ST_LCM_GCD;
                     end
                  endcase
               end
            end
         end
         ST_DONE: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         ST_EQ_SWAP: begin
            pn_in    = rn_ff;
            pd_in    = rd_ff;
            rn_in    = sgn(bn_ff, bd_ff[WORD_BITS-1]);
            rd_in    = sgn(bd_ff, bd_ff[WORD_BITS-1]);
            second_in = 1'b1;
            state_in = ST_RED_GCD;
         end
         default: begin
            if (u_done) begin
               issued_in = 1'b0;
               case (state_ff)
                  ST_LCM_GCD: begin g_in = u_res; state_in = ST_LCM_DIV; end
                  ST_LCM_DIV: begin t_in = u_res; state_in = ST_LCM_MUL; end
                  ST_LCM_MUL: begin l_in = u_res; state_in = ST_SCL_DIVA; end
                  ST_SCL_DIVA: begin
                     t_in = sgn(u_res, l_ff[WORD_BITS-1] ^ ad_ff[WORD_BITS-1]);
                     state_in = ST_SCL_MULA;
                  end
                  ST_SCL_MULA: begin pn_in = u_res; state_in = ST_SCL_DIVB; end
                  ST_SCL_DIVB: begin
                     t_in = sgn(u_res, l_ff[WORD_BITS-1] ^ bd_ff[WORD_BITS-1]);
                     state_in = ST_SCL_MULB;
                  end
                  ST_SCL_MULB: begin
                     rn_in = pn_ff + u_res;
                     rd_in = l_ff;
                     state_in = (cmd_ff inside {CMD_ADD, CMD_SUB}) ? ST_DONE
                                                                   : ST_SIGN_MUL;
                  end
                  ST_SIGN_MUL: begin
                     // sign of num * den of the difference decides the compare
                     case (cmd_ff)
                        CMD_LT:  cmp_in = p[WORD_BITS-1];
                        CMD_GT:  cmp_in = !p[WORD_BITS-1] && p != '0;
                        CMD_LE:  cmp_in = !(!p[WORD_BITS-1] && p != '0);
                        default: cmp_in = !p[WORD_BITS-1];
                     endcase
                     rn_in = '0;
                     rd_in = '0;
                     state_in = ST_DONE;
                  end
                  ST_PRD_NUM: begin rn_in = u_res; state_in = ST_PRD_DEN; end
                  ST_PRD_DEN: begin
                     // flip both signs when both parts are negative
                     if (rn_ff[WORD_BITS-1] && u_res[WORD_BITS-1]) begin
                        rn_in = word_type'(-rn_ff);
                        rd_in = word_type'(-u_res);
                     end else begin
                        rd_in = u_res;
                     end
                     state_in = ST_RED_GCD;
                  end
                  ST_RED_GCD: begin
                     g_in = u_res;
                     if (u_res != '0) begin
                        state_in = ST_RED_NUM;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  ST_RED_NUM: begin
                     rn_in = sgn(u_res, rn_ff[WORD_BITS-1]);
                     state_in = ST_RED_DEN;
                  end
                  ST_RED_DEN: begin
                     rd_in = sgn(u_res, rd_ff[WORD_BITS-1]);
                     if (cmd_ff inside {CMD_MUL, CMD_DIV}) begin
                        state_in = ST_DONE;
                     end else if (!second_ff) begin
                        state_in = ST_EQ_SWAP;
                     end else begin
                        // compare second reduced form with the saved first
                        cmp_in = (rn_ff == pn_ff) &&
                                 (sgn(u_res, rd_ff[WORD_BITS-1]) == pd_ff);
                        if (cmd_ff == CMD_NE) cmp_in = !cmp_in;
                        rn_in = '0;
                        rd_in = '0;
                        state_in = ST_DONE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      rn_ff <= rn_in; rd_ff <= rd_in; pn_ff <= pn_in; pd_ff <= pd_in;
      g_ff  <= g_in;  t_ff  <= t_in;  l_ff  <= l_in;
      cmp_ff <= cmp_in;
      err_ff <= err_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_DONE);
   assign rsp_ch.res_num      = FIELD_BITS'($signed(rn_ff));
   assign rsp_ch.res_den      = FIELD_BITS'($signed(rd_ff));
   assign rsp_ch.compare_true = cmp_ff;
   assign rsp_ch.error_code   = err_ff;

   a_done_in_op: assert property (@(posedge clock) disable iff (reset)
      u_done |-> op_state && issued_ff)
      else $error("unit finished outside an operation step");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && err_ff != ERR_OK |-> rn_ff == '0 && rd_ff == '0 && !cmp_ff)
      else $error("error result carries nonzero fields");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("new transfer taken while an item is in flight");

endmodule
